>>> design/kbm_pkg.sv
`timescale 1ns / 1ps

package kbm_pkg;

    localparam int PHYS_DEPTH = 16;
    localparam int INJ_DEPTH  = 8;
    localparam int PHYS_AW    = $clog2(PHYS_DEPTH);
    localparam int INJ_AW     = $clog2(INJ_DEPTH);

    localparam int MOD_W  = 8;
    localparam int KEYS_W = 48;

    typedef logic [PHYS_AW-1:0] phys_ptr_t;
    typedef logic [INJ_AW-1:0]  inj_ptr_t;

    typedef enum logic [1:0] {
        CMD_PUSH_PHYS = 2'd0,
        CMD_START_INJ = 2'd1,
        CMD_PUSH_INJ  = 2'd2,
        CMD_SERVICE   = 2'd3
    } cmd_t;

    // modifier in the upper byte, keys below
    typedef struct packed {
        logic [MOD_W-1:0]  modifier;
        logic [KEYS_W-1:0] keys;
    } report_t;

    typedef struct packed {
        logic    push;
        logic    pop;
        logic    flush;
        report_t wr_report;
    } phys_ctrl_t;

    typedef struct packed {
        logic    empty;
        logic    full;
        report_t head_report;
    } phys_stat_t;

    typedef struct packed {
        logic    push_pair;
        logic    pop;
        report_t press_report;
        report_t release_report;
    } inj_ctrl_t;

    typedef struct packed {
        logic    empty;
        logic    room_for_pair;
        report_t head_report;
    } inj_stat_t;

    function automatic phys_ptr_t phys_inc(input phys_ptr_t p);
        phys_ptr_t r;
        if (p == PHYS_AW'(PHYS_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PHYS_AW'(1);
        end
        return r;
    endfunction

    function automatic inj_ptr_t inj_inc(input inj_ptr_t p);
        inj_ptr_t r;
        if (p == INJ_AW'(INJ_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + INJ_AW'(1);
        end
        return r;
    endfunction

endpackage

>>> design/kbm_phys_fifo.sv
`timescale 1ns / 1ps

module kbm_phys_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  kbm_pkg::phys_ctrl_t ctrl,
    output kbm_pkg::phys_stat_t stat
);
    import kbm_pkg::*;

    report_t   mem [PHYS_DEPTH];
    phys_ptr_t head_reg;
    phys_ptr_t head_next;
    phys_ptr_t tail_reg;
    phys_ptr_t tail_next;
    report_t   rd_reg;

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        if (ctrl.push)
        begin
            tail_next = phys_inc(tail_reg);
        end
        if (ctrl.flush)
        begin
            head_next = tail_reg;
        end
        else if (ctrl.pop)
        begin
            head_next = phys_inc(head_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[tail_reg] <= ctrl.wr_report;
        end
    end

    // read the next head entry, write-first so a push into an empty ring shows up
    always_ff @(posedge clk)
    begin
        if (ctrl.push && (tail_reg == head_next))
        begin
            rd_reg <= ctrl.wr_report;
        end
        else
        begin
            rd_reg <= mem[head_next];
        end
    end

    assign stat.empty       = (head_reg == tail_reg);
    assign stat.full        = (phys_inc(tail_reg) == head_reg);
    assign stat.head_report = rd_reg;

endmodule

>>> design/kbm_inj_fifo.sv
`timescale 1ns / 1ps

module kbm_inj_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  kbm_pkg::inj_ctrl_t ctrl,
    output kbm_pkg::inj_stat_t stat
);
    import kbm_pkg::*;

    // press reports land in one bank, release reports in the other, so a pair
    // is written in the same cycle; a side bit per slot says which bank holds it
    report_t  press_mem   [INJ_DEPTH];
    report_t  release_mem [INJ_DEPTH];
    logic     bank_sel    [INJ_DEPTH];
    inj_ptr_t head_reg;
    inj_ptr_t head_next;
    inj_ptr_t tail_reg;
    inj_ptr_t tail_next;
    inj_ptr_t tail_plus1;
    report_t  press_rd_reg;
    report_t  release_rd_reg;
    logic     sel_rd_reg;

    assign tail_plus1 = inj_inc(tail_reg);

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        if (ctrl.push_pair)
        begin
            tail_next = inj_inc(tail_plus1);
        end
        if (ctrl.pop)
        begin
            head_next = inj_inc(head_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push_pair)
        begin
            press_mem[tail_reg]     <= ctrl.press_report;
            release_mem[tail_plus1] <= ctrl.release_report;
            bank_sel[tail_reg]      <= 1'b0;
            bank_sel[tail_plus1]    <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push_pair && (tail_reg == head_next))
        begin
            press_rd_reg <= ctrl.press_report;
        end
        else
        begin
            press_rd_reg <= press_mem[head_next];
        end

        if (ctrl.push_pair && (tail_plus1 == head_next))
        begin
            release_rd_reg <= ctrl.release_report;
        end
        else
        begin
            release_rd_reg <= release_mem[head_next];
        end

        priority if (ctrl.push_pair && (tail_reg == head_next))
        begin
            sel_rd_reg <= 1'b0;
        end
        else if (ctrl.push_pair && (tail_plus1 == head_next))
        begin
            sel_rd_reg <= 1'b1;
        end
        else
        begin
            sel_rd_reg <= bank_sel[head_next];
        end
    end

    assign stat.empty         = (head_reg == tail_reg);
    assign stat.room_for_pair = (tail_plus1 != head_reg) && (inj_inc(tail_plus1) != head_reg);
    assign stat.head_report   = sel_rd_reg ? release_rd_reg : press_rd_reg;

endmodule

>>> design/keyboard_report_priority_merger.sv
`timescale 1ns / 1ps

// Keyboard report priority merger.
// One command per input transaction on the s_axis side: push a physical
// report, start an injection, push an injected press/release pair, or
// service one host slot. Every input transaction yields exactly one result
// transaction on the m_axis side carrying accepted/sent flags and the report
// sent to the host (all zero when nothing is sent). With the host ready, a
// service slot sends a pending zero report first, then the oldest injected
// report, then the oldest physical one unless an injection is active;
// injection flushes the physical queue. An input register and a result
// register frame the queue decision, made in one combinational pass between
// them. Queue head entries are prefetched into registered read ports, so one
// transaction is taken every cycle while m_axis_tready is high.
// When the receiver stalls, the result register holds and the input register
// fills, then s_axis_tready drops until the result is taken.
// Reset (asynchronous, active low) empties both queues, clears the pending
// zero report and drops both valid flags; no clearing pass is needed.

module keyboard_report_priority_merger (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // modifier_a, keys_a, modifier_b, keys_b, host_ready, inject_active, zero pad
    input  logic [119:0] s_axis_tdata,
    // cmd
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_modifier, out_keys
    output logic [55:0]  m_axis_tdata,
    // accepted, sent
    output logic [1:0]   m_axis_tuser
);
    import kbm_pkg::*;

    logic         in_valid_reg;
    logic [113:0] in_data_reg;
    cmd_t         cmd_reg;
    logic         out_valid_reg;
    report_t      out_report_reg;
    logic         out_accepted_reg;
    logic         out_sent_reg;
    logic         zero_pending_reg;
    logic         zero_pending_next;

    logic         advance;
    logic         s_fire;
    report_t      rep_a;
    report_t      rep_b;
    logic         host_ready;
    logic         inject_active;

    logic         accepted_next;
    logic         sent_next;
    report_t      report_next;

    phys_ctrl_t   phys_ctrl;
    phys_stat_t   phys_stat;
    inj_ctrl_t    inj_ctrl;
    inj_stat_t    inj_stat;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_fire)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_data_reg <= s_axis_tdata[113:0];
            cmd_reg     <= cmd_t'(s_axis_tuser);
        end
    end

    assign rep_a.modifier = in_data_reg[7:0];
    assign rep_a.keys     = in_data_reg[55:8];
    assign rep_b.modifier = in_data_reg[63:56];
    assign rep_b.keys     = in_data_reg[111:64];
    assign host_ready     = in_data_reg[112];
    assign inject_active  = in_data_reg[113];

    always_comb
    begin
        phys_ctrl           = '0;
        phys_ctrl.wr_report = rep_a;
        inj_ctrl                = '0;
        inj_ctrl.press_report   = rep_a;
        inj_ctrl.release_report = rep_b;
        zero_pending_next   = zero_pending_reg;
        accepted_next       = 1'b1;
        sent_next           = 1'b0;
        report_next         = '0;

        unique case (cmd_reg)
            CMD_PUSH_PHYS:
            begin
                accepted_next  = !phys_stat.full;
                phys_ctrl.push = advance && !phys_stat.full;
            end
            CMD_START_INJ:
            begin
                phys_ctrl.flush   = advance;
                zero_pending_next = 1'b1;
            end
            CMD_PUSH_INJ:
            begin
                accepted_next      = inj_stat.room_for_pair;
                inj_ctrl.push_pair = advance && inj_stat.room_for_pair;
            end
            CMD_SERVICE:
            begin
                priority if (!host_ready)
                begin
                    sent_next = 1'b0;
                end
                else if (zero_pending_reg)
                begin
                    zero_pending_next = 1'b0;
                    sent_next         = 1'b1;
                end
                else if (!inj_stat.empty)
                begin
                    inj_ctrl.pop    = advance;
                    phys_ctrl.flush = advance;
                    sent_next       = 1'b1;
                    report_next     = inj_stat.head_report;
                end
                else if (inject_active)
                begin
                    phys_ctrl.flush = advance;
                end
                else if (!phys_stat.empty)
                begin
                    phys_ctrl.pop = advance;
                    sent_next     = 1'b1;
                    report_next   = phys_stat.head_report;
                end
                else
                begin
                    sent_next = 1'b0;
                end
            end
            default:
            begin
                accepted_next = 1'b1;
            end
        endcase
    end

    kbm_phys_fifo u_phys_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (phys_ctrl),
        .stat  (phys_stat)
    );

    kbm_inj_fifo u_inj_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (inj_ctrl),
        .stat  (inj_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_pending_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                zero_pending_reg <= zero_pending_next;
                out_valid_reg    <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_report_reg   <= report_next;
            out_accepted_reg <= accepted_next;
            out_sent_reg     <= sent_next;
        end
    end

    assign m_axis_tvalid       = out_valid_reg;
    assign m_axis_tdata[7:0]   = out_report_reg.modifier;
    assign m_axis_tdata[55:8]  = out_report_reg.keys;
    assign m_axis_tuser        = {out_sent_reg, out_accepted_reg};

endmodule

>>> design/kbm_checker.sv
`timescale 1ns / 1ps

module kbm_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [55:0]  m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);

    // a rejected push never sends anything
    a_sent_implies_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[1] && !m_axis_tuser[0]))
        else $error("report sent on a rejected transaction");

    // no report sent means an all-zero report field
    a_idle_report_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[1]) |-> (m_axis_tdata == 56'd0))
        else $error("nonzero report without sent flag");

    // a result held by the receiver stays presented
    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // with no result waiting the input side is always open
    a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    // nothing comes out right at reset release
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("result valid at reset release");

endmodule

bind keyboard_report_priority_merger kbm_checker u_kbm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

>>> verif/tb_keyboard_report_priority_merger.sv
`timescale 1ns / 1ps

module tb_keyboard_report_priority_merger;

    import kbm_pkg::*;

    typedef struct packed {
        cmd_t    cmd;
        report_t press;
        report_t release_rep;
        logic    host_ready;
        logic    inject_active;
    } kb_cmd_t;

    typedef struct packed {
        logic    accepted;
        logic    sent;
        report_t rep;
    } host_result_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [119:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [55:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    kb_cmd_t      pending_cmds[$];
    host_result_t expected_reports[$];
    int           mismatches = 0;
    int           src_idle_pct = 0;
    int           sink_idle_pct = 0;

    // shadow copy of both rings and the zero-report flag
    report_t phys_mem[PHYS_DEPTH];
    int      phys_head = 0;
    int      phys_tail = 0;
    report_t inj_mem[INJ_DEPTH];
    int      inj_head = 0;
    int      inj_tail = 0;
    logic    zero_due = 1'b0;

    keyboard_report_priority_merger dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    task automatic predict_merge(input kb_cmd_t c, output host_result_t r);
        int n1;
        int n2;
        r = '0;
        r.accepted = 1'b1;
        case (c.cmd)
            CMD_PUSH_PHYS:
            begin
                n1 = (phys_tail + 1) % PHYS_DEPTH;
                if (n1 == phys_head)
                begin
                    r.accepted = 1'b0;
                end
                else
                begin
                    phys_mem[phys_tail] = c.press;
                    phys_tail = n1;
                end
            end
            CMD_START_INJ:
            begin
                phys_head = phys_tail;
                zero_due = 1'b1;
            end
            CMD_PUSH_INJ:
            begin
                n1 = (inj_tail + 1) % INJ_DEPTH;
                n2 = (n1 + 1) % INJ_DEPTH;
                if (n1 == inj_head || n2 == inj_head)
                begin
                    r.accepted = 1'b0;
                end
                else
                begin
                    inj_mem[inj_tail] = c.press;
                    inj_mem[n1] = c.release_rep;
                    inj_tail = n2;
                end
            end
            default:
            begin
                if (!c.host_ready)
                begin
                    r.sent = 1'b0;
                end
                else if (zero_due)
                begin
                    zero_due = 1'b0;
                    r.sent = 1'b1;
                end
                else if (inj_head != inj_tail)
                begin
                    r.sent = 1'b1;
                    r.rep = inj_mem[inj_head];
                    inj_head = (inj_head + 1) % INJ_DEPTH;
                    phys_head = phys_tail;
                end
                else if (c.inject_active)
                begin
                    phys_head = phys_tail;
                end
                else if (phys_head != phys_tail)
                begin
                    r.sent = 1'b1;
                    r.rep = phys_mem[phys_head];
                    phys_head = (phys_head + 1) % PHYS_DEPTH;
                end
            end
        endcase
    endtask

    function automatic kb_cmd_t random_cmd(input cmd_t op);
        kb_cmd_t c;
        c.cmd = op;
        c.press.modifier = 8'($urandom);
        c.press.keys = 48'({$urandom, $urandom});
        c.release_rep.modifier = 8'($urandom);
        c.release_rep.keys = 48'({$urandom, $urandom});
        c.host_ready = 1'($urandom_range(0, 1));
        c.inject_active = 1'($urandom_range(0, 1));
        return c;
    endfunction

    function automatic kb_cmd_t svc(input logic rdy, input logic act);
        kb_cmd_t c;
        c = random_cmd(CMD_SERVICE);
        c.host_ready = rdy;
        c.inject_active = act;
        return c;
    endfunction

    // driver: presents queued commands, predicts each accepted transaction
    always @(posedge clk or negedge rst_n)
    begin : driver
        kb_cmd_t      taken;
        kb_cmd_t      nxt;
        host_result_t res;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                taken.cmd                  = cmd_t'(s_axis_tuser);
                taken.press.modifier       = s_axis_tdata[7:0];
                taken.press.keys           = s_axis_tdata[55:8];
                taken.release_rep.modifier = s_axis_tdata[63:56];
                taken.release_rep.keys     = s_axis_tdata[111:64];
                taken.host_ready           = s_axis_tdata[112];
                taken.inject_active        = s_axis_tdata[113];
                predict_merge(taken, res);
                expected_reports.push_back(res);
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
                begin
                    nxt = pending_cmds.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= nxt.cmd;
                    s_axis_tdata  <= {6'b0, nxt.inject_active, nxt.host_ready,
                                      nxt.release_rep.keys, nxt.release_rep.modifier,
                                      nxt.press.keys, nxt.press.modifier};
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // monitor: each result transaction against the oldest prediction
    always @(posedge clk)
    begin : monitor
        host_result_t exp_r;
        host_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.accepted     = m_axis_tuser[0];
            got.sent         = m_axis_tuser[1];
            got.rep.modifier = m_axis_tdata[7:0];
            got.rep.keys     = m_axis_tdata[55:8];
            if (expected_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result: acc=%0b sent=%0b mod=%h keys=%h",
                             got.accepted, got.sent, got.rep.modifier, got.rep.keys);
                end
            end
            else
            begin
                exp_r = expected_reports.pop_front();
                if (got.accepted !== exp_r.accepted || got.sent !== exp_r.sent ||
                    got.rep.modifier !== exp_r.rep.modifier ||
                    got.rep.keys !== exp_r.rep.keys)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: exp acc=%0b sent=%0b mod=%h keys=%h",
                                 exp_r.accepted, exp_r.sent, exp_r.rep.modifier,
                                 exp_r.rep.keys);
                        $display("          got acc=%0b sent=%0b mod=%h keys=%h",
                                 got.accepted, got.sent, got.rep.modifier, got.rep.keys);
                    end
                end
            end
        end
    end

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || s_axis_tvalid || expected_reports.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic queue_directed();
        kb_cmd_t c;
        pending_cmds.push_back(svc(1'b1, 1'b0));            // nothing queued
        c = random_cmd(CMD_PUSH_PHYS);
        c.press = '1;
        pending_cmds.push_back(c);
        c = random_cmd(CMD_PUSH_PHYS);
        c.press = '0;
        pending_cmds.push_back(c);
        pending_cmds.push_back(svc(1'b0, 1'b0));            // host not ready
        pending_cmds.push_back(svc(1'b1, 1'b0));
        pending_cmds.push_back(svc(1'b1, 1'b0));
        // four pairs: the last finds only one free slot
        c = random_cmd(CMD_PUSH_INJ);
        c.press = '1;
        c.release_rep = '0;
        pending_cmds.push_back(c);
        for (int i = 0; i < 3; i++)
        begin
            pending_cmds.push_back(random_cmd(CMD_PUSH_INJ));
        end
        pending_cmds.push_back(random_cmd(CMD_START_INJ));
        pending_cmds.push_back(random_cmd(CMD_START_INJ));  // zero report stays armed
        pending_cmds.push_back(svc(1'b1, 1'b1));            // zero report
        pending_cmds.push_back(random_cmd(CMD_PUSH_PHYS));
        for (int i = 0; i < 6; i++)
        begin
            pending_cmds.push_back(svc(1'b1, 1'b1));        // injected pops flush physical
        end
        pending_cmds.push_back(svc(1'b1, 1'b1));            // active, injected empty
        pending_cmds.push_back(random_cmd(CMD_PUSH_PHYS));
        pending_cmds.push_back(svc(1'b1, 1'b1));            // flushes without sending
        pending_cmds.push_back(svc(1'b1, 1'b0));
    endtask

    task automatic queue_random(input int count);
        int      left;
        int      burst;
        int      mode;
        int      roll;
        kb_cmd_t c;
        left = count;
        while (left > 0)
        begin
            mode  = $urandom_range(0, 3);
            burst = $urandom_range(10, 40);
            for (int i = 0; i < burst && left > 0; i++)
            begin
                c = random_cmd(cmd_t'($urandom_range(0, 3)));
                roll = $urandom_range(0, 99);
                case (mode)
                    0:
                    begin
                        // fill the physical ring past full
                        c.cmd = (roll < 85) ? CMD_PUSH_PHYS : CMD_SERVICE;
                    end
                    1:
                    begin
                        // drain toward the host
                        if (roll < 80)
                        begin
                            c = svc($urandom_range(0, 99) < 80, $urandom_range(0, 99) < 20);
                        end
                        else
                        begin
                            c.cmd = CMD_PUSH_PHYS;
                        end
                    end
                    2:
                    begin
                        // injection sequences
                        if (roll < 8)
                        begin
                            c.cmd = CMD_START_INJ;
                        end
                        else if (roll < 40)
                        begin
                            c.cmd = CMD_PUSH_INJ;
                        end
                        else if (roll < 95)
                        begin
                            c = svc($urandom_range(0, 99) < 85, $urandom_range(0, 99) < 60);
                        end
                        else
                        begin
                            c.cmd = CMD_PUSH_PHYS;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                pending_cmds.push_back(c);
                left--;
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        queue_directed();
        wait_drained();
        src_idle_pct  = 37;
        sink_idle_pct = 71;
        queue_random(240);
        wait_drained();
        src_idle_pct  = 71;
        sink_idle_pct = 37;
        queue_random(240);
        wait_drained();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        queue_random(220);
        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_reports.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

>>> sim.f
design/kbm_pkg.sv
design/kbm_phys_fifo.sv
design/kbm_inj_fifo.sv
design/keyboard_report_priority_merger.sv
design/kbm_checker.sv
verif/tb_keyboard_report_priority_merger.sv
